/* rtl/five_stage_inorder_core_macros.svh */
// assertion macros for the five-stage core
`ifndef FIVE_STAGE_INORDER_CORE_MACROS_SVH
`define FIVE_STAGE_INORDER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FSIC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsic check failed");
`define FSIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsic check failed");
`else
`define FSIC_ASSERT_SAME(label, ante, cons)
`define FSIC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/fsic_pkg.sv */
// ----------------------------------------------------------------------------
// fsic_pkg
// types, constants and datapath helpers of the five-stage in-order core
// ----------------------------------------------------------------------------
package fsic_pkg;

    localparam int PC_WIDTH        = 10;
    localparam int REG_COUNT       = 16;
    localparam int DATA_ADDR_WIDTH = 21;
    localparam int REG_IDX_W       = $clog2(REG_COUNT);

    localparam logic [REG_IDX_W-1:0] LINK_REG = REG_IDX_W'(15);
    localparam logic [4:0]           SHIFT_MASK = 5'h1F;

    localparam logic [7:0] OPC_ADD  = 8'd0;
    localparam logic [7:0] OPC_SUB  = 8'd1;
    localparam logic [7:0] OPC_AND  = 8'd2;
    localparam logic [7:0] OPC_OR   = 8'd3;
    localparam logic [7:0] OPC_XOR  = 8'd4;
    localparam logic [7:0] OPC_MUL  = 8'd5;
    localparam logic [7:0] OPC_SLL  = 8'd6;
    localparam logic [7:0] OPC_SRA  = 8'd7;
    localparam logic [7:0] OPC_SRL  = 8'd8;
    localparam logic [7:0] OPC_BEQ  = 8'd9;
    localparam logic [7:0] OPC_BNE  = 8'd10;
    localparam logic [7:0] OPC_BLT  = 8'd11;
    localparam logic [7:0] OPC_BGT  = 8'd12;
    localparam logic [7:0] OPC_BLE  = 8'd13;
    localparam logic [7:0] OPC_BGE  = 8'd14;
    localparam logic [7:0] OPC_JAL  = 8'd15;
    localparam logic [7:0] OPC_LW   = 8'd16;
    localparam logic [7:0] OPC_SW   = 8'd17;
    localparam logic [7:0] OPC_HALT = 8'd20;

    typedef struct packed {
        logic [7:0]         inst_opcode;
        logic [3:0]         inst_dest;
        logic [3:0]         inst_src_a;
        logic [3:0]         inst_src_b;
        logic signed [11:0] inst_imm;
        logic               mem_hit;
        logic signed [31:0] mem_load_word;
    } in_item_t;

    typedef struct packed {
        logic [PC_WIDTH-1:0]        fetch_pc;
        logic                       mem_read;
        logic                       mem_write;
        logic [DATA_ADDR_WIDTH-1:0] mem_address;
        logic signed [31:0]         mem_store_word;
        logic                       retired;
        logic                       decode_stalled;
        logic                       mem_stalled;
        logic                       halted;
    } out_item_t;

    function automatic logic [31:0] alu(input logic [7:0] op, input logic [31:0] a,
                                        input logic [31:0] b, input logic [31:0] link);
        logic [4:0] sh;
        logic [31:0] r;
        sh = b[4:0] & SHIFT_MASK;
        unique case (op)
            OPC_ADD, OPC_LW, OPC_SW: r = a + b;
            OPC_SUB: r = a - b;
            OPC_AND: r = a & b;
            OPC_OR:  r = a | b;
            OPC_XOR: r = a ^ b;
            OPC_MUL: r = a * b;
            OPC_SLL: r = a << sh;
            OPC_SRA: r = 32'($signed(a) >>> sh);
            OPC_SRL: r = a >> sh;
            OPC_JAL: r = link;
            default: r = '0;
        endcase
        return r;
    endfunction

    // whether an instruction writes a register
    function automatic logic writes_reg(input logic [7:0] op);
        return (op <= OPC_SRL) || (op == OPC_LW) || (op == OPC_JAL);
    endfunction

endpackage

/* rtl/fsic_in_if.sv */
// ----------------------------------------------------------------------------
// fsic_in_if / fsic_out_if
// valid/ready channels carrying one tick beat in and one result beat out
// ----------------------------------------------------------------------------
interface fsic_in_if import fsic_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface fsic_out_if import fsic_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/five_stage_inorder_core.sv */
// ----------------------------------------------------------------------------
// five_stage_inorder_core
// five-stage in-order core advanced by one beat per clock tick
// ----------------------------------------------------------------------------
// Each input beat is one core tick: it carries the instruction word at the
// previously announced fetch_pc and the data cache response for the previously
// announced access. The tick is evaluated combinationally and its result beat is
// registered, so a new tick is taken every clock while the result register is
// free or being drained. Branches resolve in decode with one delay slot; there
// is no forwarding, so decode inserts bubbles on hazards, and a cache miss
// freezes the pipeline.
module five_stage_inorder_core
    import fsic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fsic_in_if.sink     in_ch,
    fsic_out_if.source  out_ch
);
`include "five_stage_inorder_core_macros.svh"

    logic [PC_WIDTH-1:0] pc_reg;
    logic                halt_reg;
    logic                miss_reg;
    logic [31:0]         rf_reg [REG_COUNT];

    logic                 s0_valid_reg;
    logic [7:0]           s0_op_reg;
    logic [REG_IDX_W-1:0] s0_rd_reg, s0_rs_reg, s0_rt_reg;
    logic [11:0]          s0_imm_reg;
    logic [PC_WIDTH-1:0]  s0_pc_reg;

    logic                 s1_valid_reg;
    logic [7:0]           s1_op_reg;
    logic [REG_IDX_W-1:0] s1_rd_reg;
    logic [31:0]          s1_a_reg, s1_b_reg, s1_d_reg, s1_link_reg;

    logic                 s2_valid_reg;
    logic [7:0]           s2_op_reg;
    logic [REG_IDX_W-1:0] s2_rd_reg;
    logic [31:0]          s2_d_reg, s2_res_reg;

    logic                 s3_valid_reg;
    logic [7:0]           s3_op_reg;
    logic [REG_IDX_W-1:0] s3_rd_reg;
    logic [31:0]          s3_res_reg, s3_load_reg;

    logic      out_valid_reg;
    out_item_t out_reg;

    logic                 accept;
    logic                 wb_we, halt_next, miss, stall, taken;
    logic [REG_IDX_W-1:0] wb_dst;
    logic [31:0]          wb_val, exres, opa, opb, opd, imm_ext;
    logic [PC_WIDTH-1:0]  pc_next;
    out_item_t            out_next;
    logic                 a2_valid;
    logic [7:0]           a2_op;
    logic [31:0]          a2_d, a2_res;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    function automatic logic dest_hit(input logic v, input logic [7:0] op,
                                      input logic [REG_IDX_W-1:0] rd,
                                      input logic [REG_IDX_W-1:0] r);
        return v && ((((op <= OPC_SRL) || (op == OPC_LW)) && rd == r)
                     || (op == OPC_JAL && r == LINK_REG));
    endfunction

    function automatic logic busy(input logic [REG_IDX_W-1:0] r,
        input logic v1, input logic [7:0] o1, input logic [REG_IDX_W-1:0] d1,
        input logic v2, input logic [7:0] o2, input logic [REG_IDX_W-1:0] d2,
        input logic v3, input logic [7:0] o3, input logic [REG_IDX_W-1:0] d3);
        return (r > REG_IDX_W'(1)) && (dest_hit(v1, o1, d1, r) || dest_hit(v2, o2, d2, r)
                                    || dest_hit(v3, o3, d3, r));
    endfunction

    // decode read: R0 zero, R1 current immediate, bypass from this tick's writeback
    function automatic logic [31:0] rd_reg(input logic [REG_IDX_W-1:0] r,
        input logic [31:0] imm, input logic we, input logic [REG_IDX_W-1:0] dst,
        input logic [31:0] val, input logic [31:0] stored);
        logic [31:0] v;
        if (r == '0)
            v = '0;
        else if (r == REG_IDX_W'(1))
            v = imm;
        else if (we && dst == r)
            v = val;
        else
            v = stored;
        return v;
    endfunction

    always_comb
    begin
        // writeback
        wb_dst = (s3_op_reg == OPC_JAL) ? LINK_REG : s3_rd_reg;
        wb_val = (s3_op_reg == OPC_LW) ? s3_load_reg : s3_res_reg;
        wb_we = s3_valid_reg && writes_reg(s3_op_reg) && (wb_dst > REG_IDX_W'(1));
        halt_next = halt_reg || (s3_valid_reg && s3_op_reg == OPC_HALT);

        miss = s2_valid_reg && (s2_op_reg == OPC_LW || s2_op_reg == OPC_SW)
               && !in_ch.payload.mem_hit;

        stall = s0_valid_reg && (
            busy(s0_rs_reg, s1_valid_reg, s1_op_reg, s1_rd_reg, s2_valid_reg, s2_op_reg,
                 s2_rd_reg, s3_valid_reg, s3_op_reg, s3_rd_reg)
            || busy(s0_rt_reg, s1_valid_reg, s1_op_reg, s1_rd_reg, s2_valid_reg, s2_op_reg,
                    s2_rd_reg, s3_valid_reg, s3_op_reg, s3_rd_reg)
            || ((((s0_op_reg >= OPC_BEQ) && (s0_op_reg <= OPC_JAL)) || s0_op_reg == OPC_SW)
                && busy(s0_rd_reg, s1_valid_reg, s1_op_reg, s1_rd_reg, s2_valid_reg,
                        s2_op_reg, s2_rd_reg, s3_valid_reg, s3_op_reg, s3_rd_reg)));

        exres = alu(s1_op_reg, s1_a_reg, s1_b_reg, s1_link_reg);

        imm_ext = 32'($signed(s0_imm_reg));
        opa = rd_reg(s0_rs_reg, imm_ext, wb_we, wb_dst, wb_val, rf_reg[s0_rs_reg]);
        opb = rd_reg(s0_rt_reg, imm_ext, wb_we, wb_dst, wb_val, rf_reg[s0_rt_reg]);
        opd = rd_reg(s0_rd_reg, imm_ext, wb_we, wb_dst, wb_val, rf_reg[s0_rd_reg]);

        unique case (s0_op_reg)
            OPC_BEQ: taken = opa == opb;
            OPC_BNE: taken = opa != opb;
            OPC_BLT: taken = $signed(opa) < $signed(opb);
            OPC_BGT: taken = $signed(opa) > $signed(opb);
            OPC_BLE: taken = $signed(opa) <= $signed(opb);
            OPC_BGE: taken = $signed(opa) >= $signed(opb);
            OPC_JAL: taken = 1'b1;
            default: taken = 1'b0;
        endcase
        taken = taken && s0_valid_reg && !stall;

        if (miss || stall)
            pc_next = pc_reg;
        else if (taken)
            pc_next = opd[PC_WIDTH-1:0];
        else if (!halt_next)
            pc_next = pc_reg + PC_WIDTH'(1);
        else
            pc_next = pc_reg;

        // memory-stage view after this tick
        if (miss)
        begin
            a2_valid = s2_valid_reg;
            a2_op = s2_op_reg;
            a2_d = s2_d_reg;
            a2_res = s2_res_reg;
        end
        else
        begin
            a2_valid = s1_valid_reg;
            a2_op = s1_op_reg;
            a2_d = s1_d_reg;
            a2_res = exres;
        end

        out_next.fetch_pc = pc_next;
        out_next.mem_read = a2_valid && a2_op == OPC_LW;
        out_next.mem_write = a2_valid && a2_op == OPC_SW;
        out_next.mem_address = (out_next.mem_read || out_next.mem_write)
                               ? a2_res[DATA_ADDR_WIDTH-1:0] : '0;
        out_next.mem_store_word = out_next.mem_write ? a2_d : '0;
        out_next.retired = s3_valid_reg;
        out_next.decode_stalled = !miss && stall;
        out_next.mem_stalled = miss;
        out_next.halted = halt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
            halt_reg <= 1'b0;
            miss_reg <= 1'b0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
                rf_reg[i] <= '0;
        end
        else
        begin
            if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                out_reg <= out_next;
                halt_reg <= halt_next;
                miss_reg <= miss;
                pc_reg <= pc_next;
                if (wb_we)
                    rf_reg[wb_dst] <= wb_val;
                if (miss)
                    s3_valid_reg <= 1'b0;
                else
                begin
                    s3_valid_reg <= s2_valid_reg;
                    s3_op_reg <= s2_op_reg;
                    s3_rd_reg <= s2_rd_reg;
                    s3_res_reg <= s2_res_reg;
                    if (s2_valid_reg && s2_op_reg == OPC_LW)
                        s3_load_reg <= in_ch.payload.mem_load_word;
                    s2_valid_reg <= s1_valid_reg;
                    s2_op_reg <= s1_op_reg;
                    s2_rd_reg <= s1_rd_reg;
                    s2_d_reg <= s1_d_reg;
                    s2_res_reg <= exres;
                    if (stall || !s0_valid_reg)
                        s1_valid_reg <= 1'b0;
                    else
                    begin
                        s1_valid_reg <= 1'b1;
                        s1_op_reg <= s0_op_reg;
                        s1_rd_reg <= s0_rd_reg;
                        s1_a_reg <= opa;
                        s1_b_reg <= opb;
                        s1_d_reg <= opd;
                        // link address wraps at the fetch address width
                        s1_link_reg <= 32'(PC_WIDTH'(s0_pc_reg + PC_WIDTH'(1)));
                    end
                    if (!stall)
                    begin
                        s0_valid_reg <= !halt_next;
                        if (!halt_next)
                        begin
                            s0_op_reg <= in_ch.payload.inst_opcode;
                            s0_rd_reg <= in_ch.payload.inst_dest;
                            s0_rs_reg <= in_ch.payload.inst_src_a;
                            s0_rt_reg <= in_ch.payload.inst_src_b;
                            s0_imm_reg <= in_ch.payload.inst_imm;
                            s0_pc_reg <= pc_reg;
                        end
                    end
                end
            end
        end
    end

    // a frozen tick leaves fetch address and decode untouched
    `FSIC_ASSERT_NEXT(a_miss_freeze, accept && miss, pc_reg == $past(pc_reg) && miss_reg)
    `FSIC_ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg)
    `FSIC_ASSERT_SAME(a_one_access, out_valid_reg, !(out_reg.mem_read && out_reg.mem_write))
    `FSIC_ASSERT_SAME(a_no_stall_on_miss, out_valid_reg && out_reg.mem_stalled,
                      !out_reg.decode_stalled)

endmodule
